// ===== rtl/mle_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Maidenhead locator encoder package
// Shared widths, constants, types and digit tables for the locator encoder.
// ----------------------------------------------------------------------------
package mle_pkg;

	// Number of character pairs the encoder can produce per coordinate.
	localparam int unsigned NUM_PAIRS     = 5;
	localparam int unsigned DEFAULT_PAIRS = 3;
	localparam int unsigned FALLBACK_PAIRS =
		(DEFAULT_PAIRS < NUM_PAIRS) ? DEFAULT_PAIRS : NUM_PAIRS;

	// Field widths.
	localparam int unsigned LON_W   = 21;
	localparam int unsigned LAT_W   = 20;
	localparam int unsigned SUM_W   = 22;
	localparam int unsigned REM_W   = 20;
	localparam int unsigned DIV_W   = 21;
	localparam int unsigned CHAR_W  = 7;
	localparam int unsigned DIGIT_W = 5;
	localparam int unsigned POS_W   = $clog2(NUM_PAIRS);
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned ADDR_W  = 3;

	// Offsets and clamp limits in units of 1/5760 degree.
	localparam int unsigned LON_OFFSET = 1036800;
	localparam int unsigned LAT_OFFSET = 518400;
	localparam int unsigned LON_MAX    = 2073599;
	localparam int unsigned LAT_MAX    = 1036799;

	// Place values in units of 1/5760 degree of latitude, which equal
	// units of 1/2880 degree of longitude once the longitude is halved.
	localparam int unsigned FIELD_UNITS  = 57600;
	localparam int unsigned SQUARE_UNITS = 5760;
	localparam int unsigned SUBSQ_UNITS  = 240;
	localparam int unsigned EXT_UNITS    = 24;
	localparam int unsigned PREC_UNITS   = 1;
	localparam int unsigned MAX_RADIX    = 24;

	// ASCII bases for letter and digit positions.
	localparam logic [CHAR_W-1:0] ASCII_A    = 7'd65;
	localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'd48;

	// Register map, as word indexes.
	localparam logic [ADDR_W-3:0] REG_PAIR_COUNT = 1'b0;

	// Position of a character pair within the locator.
	typedef enum logic [POS_W-1:0] {
		POS_FIELD  = 3'd0,
		POS_SQUARE = 3'd1,
		POS_SUBSQ  = 3'd2,
		POS_EXT    = 3'd3,
		POS_PREC   = 3'd4
	} pos_t;

	typedef logic [NUM_PAIRS-1:0][CHAR_W-1:0] char_row_t;

	// One item travelling down the cell chain.
	typedef struct packed {
		char_row_t        lon_chars;
		char_row_t        lat_chars;
		logic [REM_W-1:0] lon_rem;
		logic [REM_W-1:0] lat_rem;
	} work_t;

	// Digit and remainder produced by one cell lane.
	typedef struct packed {
		logic [DIGIT_W-1:0] digit;
		logic [REM_W-1:0]   rem;
	} digit_res_t;

	// Radix of the digit at a position.
	function automatic logic [DIGIT_W-1:0] cell_radix(input pos_t pos);
		logic [DIGIT_W-1:0] r;
		case (pos)
			POS_FIELD:  r = 5'd18;
			POS_SQUARE: r = 5'd10;
			POS_SUBSQ:  r = 5'd24;
			POS_EXT:    r = 5'd10;
			POS_PREC:   r = 5'd24;
			default:    r = 5'd1;
		endcase
		return r;
	endfunction

	// k times the place value of a position; k is a constant after unrolling.
	function automatic logic [DIV_W-1:0] cell_multiple(input pos_t pos, input int unsigned k);
		logic [DIV_W-1:0] m;
		case (pos)
			POS_FIELD:  m = DIV_W'(k * FIELD_UNITS);
			POS_SQUARE: m = DIV_W'(k * SQUARE_UNITS);
			POS_SUBSQ:  m = DIV_W'(k * SUBSQ_UNITS);
			POS_EXT:    m = DIV_W'(k * EXT_UNITS);
			POS_PREC:   m = DIV_W'(k * PREC_UNITS);
			default:    m = '0;
		endcase
		return m;
	endfunction

	// Square and extended positions are numerals, the others letters.
	function automatic logic is_digit_pos(input pos_t pos);
		return (pos == POS_SQUARE) || (pos == POS_EXT);
	endfunction

endpackage
`default_nettype wire

// ===== rtl/mle_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Locator digit cell
// Extracts one mixed-radix digit from both remainders, writes its character
// into the item's row and hands the item with the new remainders onwards.
// ----------------------------------------------------------------------------
module mle_cell import mle_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire pos_t  pos,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire work_t in_work,
	output logic       out_valid,
	input  wire logic  out_ready,
	output work_t      out_work
);

	logic       valid_q;
	work_t      work_q;
	work_t      next_work;
	digit_res_t lon_res;
	digit_res_t lat_res;
	logic [CHAR_W-1:0] char_base;

	// Digit by parallel comparison against every multiple of the place value.
	function automatic digit_res_t extract(input logic [REM_W-1:0] value, input pos_t p);
		digit_res_t       res;
		logic [DIV_W-1:0] step;
		logic [DIV_W-1:0] sub;
		logic [DIGIT_W-1:0] radix;
		radix     = cell_radix(p);
		sub       = '0;
		res.digit = '0;
		for (int unsigned k = 1; k < MAX_RADIX; k++) begin
			step = cell_multiple(p, k);
			if ((DIGIT_W'(k) < radix) && ({1'b0, value} >= step)) begin
				res.digit = DIGIT_W'(k);
				sub       = step;
			end
		end
		res.rem = value - sub[REM_W-1:0];
		return res;
	endfunction

	// Digit extraction for both lanes and character encoding.
	always_comb begin
		lon_res   = extract(in_work.lon_rem, pos);
		lat_res   = extract(in_work.lat_rem, pos);
		char_base = is_digit_pos(pos) ? ASCII_ZERO : ASCII_A;
		next_work = in_work;
		next_work.lon_rem        = lon_res.rem;
		next_work.lat_rem        = lat_res.rem;
		next_work.lon_chars[pos] = char_base + CHAR_W'(lon_res.digit);
		next_work.lat_chars[pos] = char_base + CHAR_W'(lat_res.digit);
	end

	// The cell takes a new item when empty or when its item moves on.
	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			work_q <= next_work;
		end
	end

	assign out_valid = valid_q;
	assign out_work  = work_q;

endmodule
`default_nettype wire

// ===== rtl/mle_ser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Locator pair serialiser
// Holds one finished locator and sends its character pairs one per item,
// marking the final pair.
// ----------------------------------------------------------------------------
module mle_ser import mle_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [POS_W-1:0]  pairs,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire work_t             in_work,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [CHAR_W-1:0]      lon_char,
	output logic [CHAR_W-1:0]      lat_char,
	output logic                   last_pair
);

	logic             valid_q;
	logic [POS_W-1:0] left_q;
	char_row_t        lon_q;
	char_row_t        lat_q;
	logic             last;
	logic             fire;

	assign last     = (left_q == '0);
	assign fire     = valid_q && out_ready;
	assign in_ready = !valid_q || (out_ready && last);

	// Control: a new locator loads as the final pair of the previous one leaves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			left_q  <= '0;
		end else if (in_ready) begin
			valid_q <= in_valid;
			left_q  <= pairs - POS_W'(1);
		end else if (fire) begin
			left_q  <= left_q - POS_W'(1);
		end
	end

	// Character rows shift down so the current pair is always in slot zero.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			lon_q <= in_work.lon_chars;
			lat_q <= in_work.lat_chars;
		end else if (fire) begin
			lon_q <= {CHAR_W'(0), lon_q[NUM_PAIRS-1:1]};
			lat_q <= {CHAR_W'(0), lat_q[NUM_PAIRS-1:1]};
		end
	end

	assign out_valid = valid_q;
	assign lon_char  = lon_q[0];
	assign lat_char  = lat_q[0];
	assign last_pair = last;

endmodule
`default_nettype wire

// ===== rtl/maidenhead_locator_encoder_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// An item passes the input register, the five cell registers and the serialiser in turn.
// The serialiser sends pair-count (1 to 5) character pairs, one per cycle while m_tready
// is high, taking a new item with the last; each cell takes an item a cycle unless stalled.
// Reset (arst_n low) empties the pipeline and sets the pair count to 3.
// ----------------------------------------------------------------------------
// Maidenhead locator encoder
// Offsets and clamps a coordinate pair, extracts locator digits in a chain of
// five cells and streams the character pairs out with a last mark.
// ----------------------------------------------------------------------------
module maidenhead_locator_encoder_unit import mle_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// Input items
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [47:0]       s_tdata,  // [20:0] longitude, [40:21] latitude, rest zero
	// Result items
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [15:0]            m_tdata,  // [6:0] lon_char, [13:7] lat_char, rest zero
	output logic                   m_tlast,
	// Configuration port
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0]      prdata,
	output logic                   pready
);

	logic [2:0]        pair_count_q;
	logic [POS_W-1:0]  pairs;
	logic              prep_valid_q;
	work_t             prep_work_q;
	logic              prep_ready;
	work_t             prep_work;
	logic signed [SUM_W-1:0] lon_sum;
	logic signed [SUM_W-1:0] lat_sum;
	logic [LON_W-1:0]  lon_clamp;
	logic [LAT_W-1:0]  lat_clamp;
	logic [CHAR_W-1:0] lon_char;
	logic [CHAR_W-1:0] lat_char;

	logic  chain_valid [NUM_PAIRS+1];
	logic  chain_ready [NUM_PAIRS+1];
	work_t chain_work  [NUM_PAIRS+1];

	// Register access; the word index sits above the byte lane bits.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_count_q <= 3'(DEFAULT_PAIRS);
		end else if (psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_PAIR_COUNT)) begin
			pair_count_q <= pwdata[2:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[ADDR_W-1:2] == REG_PAIR_COUNT) begin
			prdata = DATA_W'(pair_count_q);
		end
	end

	// Out-of-range counts fall back to the default length.
	assign pairs = ((pair_count_q == '0) || (pair_count_q > 3'(NUM_PAIRS)))
		? POS_W'(FALLBACK_PAIRS) : POS_W'(pair_count_q);

	// Offset to non-negative spans and clamp to the last cell.
	always_comb begin
		lon_sum = SUM_W'($signed(s_tdata[LON_W-1:0])) + SUM_W'(LON_OFFSET);
		lat_sum = SUM_W'($signed(s_tdata[LON_W+LAT_W-1:LON_W])) + SUM_W'(LAT_OFFSET);
		if (lon_sum < 0) begin
			lon_clamp = '0;
		end else if (lon_sum > SUM_W'(LON_MAX)) begin
			lon_clamp = LON_W'(LON_MAX);
		end else begin
			lon_clamp = lon_sum[LON_W-1:0];
		end
		if (lat_sum < 0) begin
			lat_clamp = '0;
		end else if (lat_sum > SUM_W'(LAT_MAX)) begin
			lat_clamp = LAT_W'(LAT_MAX);
		end else begin
			lat_clamp = lat_sum[LAT_W-1:0];
		end
		prep_work           = '0;
		// Longitude counts in 1/2880 degree so both lanes share place values.
		prep_work.lon_rem   = lon_clamp[LON_W-1:1];
		prep_work.lat_rem   = lat_clamp;
	end

	// Input stage register.
	assign s_tready = !prep_valid_q || prep_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prep_valid_q <= 1'b0;
		end else if (s_tready) begin
			prep_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			prep_work_q <= prep_work;
		end
	end

	assign chain_valid[0] = prep_valid_q;
	assign chain_work[0]  = prep_work_q;
	assign prep_ready     = chain_ready[0];

	// One cell per locator pair position.
	for (genvar g = 0; g < NUM_PAIRS; g++) begin : g_cell
		mle_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.pos      (pos_t'(POS_W'(g))),
			.in_valid (chain_valid[g]),
			.in_ready (chain_ready[g]),
			.in_work  (chain_work[g]),
			.out_valid(chain_valid[g+1]),
			.out_ready(chain_ready[g+1]),
			.out_work (chain_work[g+1])
		);
	end

	// Output serialiser.
	mle_ser u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.pairs    (pairs),
		.in_valid (chain_valid[NUM_PAIRS]),
		.in_ready (chain_ready[NUM_PAIRS]),
		.in_work  (chain_work[NUM_PAIRS]),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.lon_char (lon_char),
		.lat_char (lat_char),
		.last_pair(m_tlast)
	);

	assign m_tdata = {2'b00, lat_char, lon_char};

endmodule
`default_nettype wire

// ===== rtl/mle_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Locator encoder port checker
// Watches the top-level ports for stream and register behaviour over time.
// ----------------------------------------------------------------------------
module mle_chk import mle_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              s_tvalid,
	input wire logic              s_tready,
	input wire logic [47:0]       s_tdata,
	input wire logic              m_tvalid,
	input wire logic              m_tready,
	input wire logic [15:0]       m_tdata,
	input wire logic              m_tlast,
	input wire logic              psel,
	input wire logic              penable,
	input wire logic              pwrite,
	input wire logic [ADDR_W-1:0] paddr,
	input wire logic [DATA_W-1:0] pwdata,
	input wire logic [DATA_W-1:0] prdata,
	input wire logic              pready
);

	// A stalled result item holds its pair and last mark.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result item changed while stalled");

	// Characters lie between '0' and 'X', with zero padding above.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[6:0] >= 7'd48) && (m_tdata[6:0] <= 7'd88) &&
			(m_tdata[13:7] >= 7'd48) && (m_tdata[13:7] <= 7'd88) && (m_tdata[15:14] == 2'b00))
		else $error("locator character out of range");

	// The pairs of one locator follow each other without a gap.
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("gap inside a locator");

	// A pair count write reads back on the next cycle.
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && (paddr[ADDR_W-1:2] == REG_PAIR_COUNT)
		|=> (paddr[ADDR_W-1:2] != REG_PAIR_COUNT) || (prdata == DATA_W'($past(pwdata[2:0]))))
		else $error("pair count read-back mismatch");

endmodule

bind maidenhead_locator_encoder_unit mle_chk u_mle_chk (.*);
`default_nettype wire

// ===== tb/tb_maidenhead_locator_encoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Maidenhead locator encoder regression
// Streams coordinate pairs into the encoder and compares every character
// pair that comes back with an independent prediction. The prediction offsets
// and clamps each coordinate and splits it by the exact place values. The
// pair count is changed between phases over the APB port. Phases vary the
// idling on both stream interfaces, and one phase holds the output back long
// enough to stall the input.
// ----------------------------------------------------------------------------
module tb_maidenhead_locator_encoder_unit;
	import mle_pkg::*;

	localparam int RUN_LIMIT    = 200000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 30;
	localparam int NUM_PHASES   = 10;

	// Register addresses; index 1 has no register behind it.
	localparam logic [ADDR_W-1:0] PAIR_COUNT_ADDR = {REG_PAIR_COUNT, 2'b00};
	localparam logic [ADDR_W-1:0] UNUSED_ADDR     = 3'd4;

	typedef struct packed {
		logic [LAT_W-1:0] latitude;
		logic [LON_W-1:0] longitude;
	} coord_t;

	typedef struct packed {
		logic [CHAR_W-1:0] lon_char;
		logic [CHAR_W-1:0] lat_char;
		logic              last_pair;
	} locator_pair_t;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [47:0]       s_tdata  = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [15:0]       m_tdata;
	logic              m_tlast;
	logic              psel     = 1'b0;
	logic              penable  = 1'b0;
	logic              pwrite   = 1'b0;
	logic [ADDR_W-1:0] paddr    = '0;
	logic [DATA_W-1:0] pwdata   = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	// Place values per pair position, in 1/5760 degree units.
	int unsigned lon_place [NUM_PAIRS] = '{115200, 11520, 480, 48, 2};
	int unsigned lat_place [NUM_PAIRS] = '{57600, 5760, 240, 24, 1};

	coord_t        pending_coords[$];
	locator_pair_t pairs_due[$];
	logic [2:0]    cfg_pairs   = 3'(DEFAULT_PAIRS);
	int            tx_idle_pct = 0;
	int            rx_idle_pct = 0;
	int            failures    = 0;
	int            cycle_count = 0;
	logic          hold_req    = 1'b0;
	logic          hold_done   = 1'b0;
	int            hold_count  = 0;

	maidenhead_locator_encoder_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Works out the character pairs of one coordinate and queues them.
	function automatic void predict_locator(input coord_t c, input logic [2:0] count_reg);
		longint        lon_units;
		longint        lat_units;
		int unsigned   n;
		int unsigned   lon_digit;
		int unsigned   lat_digit;
		logic [CHAR_W-1:0] base;
		locator_pair_t p;
		lon_units = longint'($signed(c.longitude)) + longint'(LON_OFFSET);
		lat_units = longint'($signed(c.latitude)) + longint'(LAT_OFFSET);
		if (lon_units < 0)
			lon_units = 0;
		else if (lon_units > longint'(LON_MAX))
			lon_units = longint'(LON_MAX);
		if (lat_units < 0)
			lat_units = 0;
		else if (lat_units > longint'(LAT_MAX))
			lat_units = longint'(LAT_MAX);
		n = count_reg;
		if (n < 1 || n > NUM_PAIRS)
			n = FALLBACK_PAIRS;
		for (int i = 0; i < n; i++) begin
			lon_digit = int'(lon_units / longint'(lon_place[i]));
			lat_digit = int'(lat_units / longint'(lat_place[i]));
			lon_units = lon_units % longint'(lon_place[i]);
			lat_units = lat_units % longint'(lat_place[i]);
			// Square and extended positions are numerals, the rest letters.
			base = (i % 2) ? ASCII_ZERO : ASCII_A;
			p.lon_char  = CHAR_W'(base + lon_digit);
			p.lat_char  = CHAR_W'(base + lat_digit);
			p.last_pair = (i == n - 1);
			pairs_due.push_back(p);
		end
	endfunction

	function automatic void queue_coord(input int lon, input int lat);
		coord_t c;
		c.longitude = LON_W'(lon);
		c.latitude  = LAT_W'(lat);
		pending_coords.push_back(c);
	endfunction

	// Draws one coordinate: mostly in range, some on cell edges, some raw.
	function automatic int pick_coord(input bit is_lon);
		int          half;
		int          kind;
		int          v;
		int unsigned place;
		half = is_lon ? int'(LON_OFFSET) : int'(LAT_OFFSET);
		kind = $urandom_range(99);
		if (kind < 60) begin
			v = int'($urandom_range(2 * half)) - half;
		end else if (kind < 78) begin
			place = is_lon ? lon_place[$urandom_range(NUM_PAIRS - 1)]
			               : lat_place[$urandom_range(NUM_PAIRS - 1)];
			v = int'($urandom_range(2 * half / place)) * int'(place) - half
				+ int'($urandom_range(2)) - 1;
		end else if (kind < 90) begin
			v = $urandom();
			v = is_lon ? int'($signed(LON_W'(v))) : int'($signed(LAT_W'(v)));
		end else begin
			v = ($urandom_range(1) ? half : -half) + int'($urandom_range(2)) - 1;
		end
		return v;
	endfunction

	task automatic queue_random_coords(input int count);
		for (int i = 0; i < count; i++)
			queue_coord(pick_coord(1'b1), pick_coord(1'b0));
	endtask

	task automatic write_register(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == PAIR_COUNT_ADDR)
			cfg_pairs = data[2:0];
	endtask

	task automatic wait_until_idle();
		while (pending_coords.size() != 0 || s_tvalid || pairs_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic log_failure(input string msg);
		failures++;
		if (failures <= 10)
			$display("%0t: %s", $time, msg);
	endtask

	// Sender: presents queued items, idling at random between them.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				predict_locator(coord_t'(s_tdata[40:0]), cfg_pairs);
			if (!s_tvalid || s_tready) begin
				if (pending_coords.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata  <= {7'b0, pending_coords.pop_front()};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver readiness, with one long hold-off when requested.
	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			m_tready   <= 1'b0;
			hold_count <= hold_count + 1;
			if (hold_count == HOLD_CYCLES - 1)
				hold_done <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Checks every accepted character pair against the oldest one due.
	always @(posedge clk) begin
		locator_pair_t got;
		locator_pair_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.lon_char  = m_tdata[6:0];
			got.lat_char  = m_tdata[13:7];
			got.last_pair = m_tlast;
			if (pairs_due.size() == 0) begin
				log_failure($sformatf("unexpected item lon 0x%02h lat 0x%02h last %0b",
					got.lon_char, got.lat_char, got.last_pair));
			end else begin
				want = pairs_due.pop_front();
				if (got.lon_char !== want.lon_char || got.lat_char !== want.lat_char ||
				    got.last_pair !== want.last_pair)
					log_failure($sformatf(
						"mismatch: expected lon 0x%02h lat 0x%02h last %0b, got lon 0x%02h lat 0x%02h last %0b",
						want.lon_char, want.lat_char, want.last_pair,
						got.lon_char, got.lat_char, got.last_pair));
			end
		end
	end

	// Guards against a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("maidenhead_locator_encoder_unit regression: fail");
			$finish;
		end
	end

	// Phase sequence: pair count settings, idling modes and stimulus.
	initial begin
		logic [DATA_W-1:0] phase_word [NUM_PHASES];
		phase_word = '{32'd3, 32'd5, 32'd1, 32'd0, 32'd7, 32'hFFFF_FFFA,
			32'd5, 32'd6, 32'd4, 32'd1};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph < 3) begin
				tx_idle_pct = 27;
				rx_idle_pct = 87;
			end else if (ph < 6) begin
				tx_idle_pct = 87;
				rx_idle_pct = 27;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			// The first phase runs on the reset value of the pair count.
			if (ph != 0)
				write_register(PAIR_COUNT_ADDR, phase_word[ph]);
			// A write to an empty slot must leave the pair count alone.
			if (ph == 1)
				write_register(UNUSED_ADDR, 32'h1);
			if (ph == 6)
				hold_req <= 1'b1;
			if (ph == 0) begin
				// Nominal extremes, and the upper edges that saturate.
				queue_coord(-1036800, -518400);
				queue_coord(1036800, 518400);
				queue_coord(1036799, 518399);
				queue_coord(1036800, -518400);
				queue_coord(-1036800, 518400);
				queue_coord(0, 0);
				queue_coord(-1, -1);
				queue_coord(1, 1);
				// Raw field extremes and values just outside the range.
				queue_coord(-1048576, -524288);
				queue_coord(1048575, 524287);
				queue_coord(-1036801, -518401);
				queue_coord(1036801, 518401);
				// Cell boundaries at each position.
				queue_coord(-921600, -460800);
				queue_coord(-921601, -460801);
				queue_coord(-1025280, -512640);
				queue_coord(-1036320, -518160);
				queue_coord(-1036753, -518377);
				queue_coord(-1036799, -518399);
				// Alternating bit patterns.
				queue_coord(int'($signed(21'h0AAAAA)), int'($signed(20'h55555)));
				queue_coord(int'($signed(21'h155555)), int'($signed(20'hAAAAA)));
				queue_random_coords(24);
			end else begin
				queue_random_coords(34);
			end
			wait_until_idle();
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0 && pairs_due.size() == 0)
			$display("maidenhead_locator_encoder_unit regression: pass");
		else
			$display("maidenhead_locator_encoder_unit regression: fail");
		$finish;
	end

endmodule
